// File: rtl/upc_pkg.sv
package upc_pkg;

  localparam int unsigned CableCountDef = 4;

  localparam logic CmdDecode = 1'b0;
  localparam logic CmdEncode = 1'b1;

  localparam logic KindStreamByte = 1'b0;
  localparam logic KindPacket     = 1'b1;

  localparam logic [3:0] CinTwoByteCommon   = 4'h2;
  localparam logic [3:0] CinThreeByteCommon = 4'h3;
  localparam logic [3:0] CinSysexStart      = 4'h4;
  localparam logic [3:0] CinSingleByte      = 4'h5;
  localparam logic [3:0] CinSysexEndTwo     = 4'h6;
  localparam logic [3:0] CinSysexEndThree   = 4'h7;

  localparam logic [7:0] StatusSysexStart   = 8'hF0;
  localparam logic [7:0] StatusTimeCode     = 8'hF1;
  localparam logic [7:0] StatusSongPosition = 8'hF2;
  localparam logic [7:0] StatusSongSelect   = 8'hF3;
  localparam logic [7:0] StatusTuneRequest  = 8'hF6;
  localparam logic [7:0] StatusSysexEnd     = 8'hF7;
  localparam logic [7:0] StatusClock        = 8'hF8;
  localparam logic [7:0] StatusStart        = 8'hFA;
  localparam logic [7:0] StatusContinue     = 8'hFB;
  localparam logic [7:0] StatusStop         = 8'hFC;
  localparam logic [7:0] StatusActiveSense  = 8'hFE;
  localparam logic [7:0] StatusReset        = 8'hFF;

  localparam logic [3:0] NibbleSystem = 4'hF;

  typedef struct packed {
    logic       command;
    logic [7:0] header_byte;
    logic [3:0] cable_number;
    logic [1:0] message_length;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
  } upc_item_t;

  typedef struct packed {
    logic            kind;
    logic [3:0]      port;
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic [31:0]     word;
  } upc_run_t;

  function automatic logic [1:0] decode_count(input logic [3:0] cin);
    logic [1:0] n;
    case (cin)
      4'h5, 4'hF:                               n = 2'd1;
      4'h2, 4'h6, 4'hC, 4'hD:                   n = 2'd2;
      4'h3, 4'h4, 4'h7, 4'h8, 4'h9, 4'hA, 4'hB,
      4'hE:                                     n = 2'd3;
      default:                                  n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] encode_cin(input logic [7:0] status, input logic [1:0] len,
                                            input logic [7:0] d0, input logic [7:0] d1);
    logic [3:0] cin;
    if (status[7] && (status[7:4] != NibbleSystem)) begin
      cin = status[7:4];
    end else begin
      case (status)
        StatusTimeCode, StatusSongSelect: cin = CinTwoByteCommon;
        StatusSongPosition:               cin = CinThreeByteCommon;
        StatusSysexStart:                 cin = CinSysexStart;
        StatusTuneRequest, StatusClock, StatusStart, StatusContinue, StatusStop,
        StatusActiveSense, StatusReset:   cin = CinSingleByte;
        default: begin
          if (len == 2'd2) begin
            cin = (d0 == StatusSysexEnd) ? CinSysexEndTwo : CinTwoByteCommon;
          end else if (len == 2'd3) begin
            cin = (d1 == StatusSysexEnd) ? CinSysexEndThree : CinThreeByteCommon;
          end else begin
            cin = CinSingleByte;
          end
        end
      endcase
    end
    return cin;
  endfunction

endpackage

// File: rtl/upc_in_stage.sv
module upc_in_stage import upc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  upc_item_t item_i,
  input  logic      load_i,
  output logic      item_valid_o,
  output upc_item_t item_o
);

  logic      valid_q, valid_d;
  upc_item_t item_q;

  assign in_ready_o   = !valid_q || load_i;
  assign valid_d      = in_ready_o ? in_valid_i : valid_q;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// File: rtl/upc_pack.sv
module upc_pack import upc_pkg::*; #(
  parameter int unsigned CABLE_COUNT = CableCountDef
) (
  input  upc_item_t item_i,
  output upc_run_t  run_o
);

  logic [3:0] dec_cable;
  logic       cable_ok;
  logic [3:0] cin;
  logic [7:0] p2, p3;

  always_comb begin
    dec_cable = item_i.header_byte[7:4];
    cable_ok  = {1'b0, dec_cable} < 5'(CABLE_COUNT);
    cin       = encode_cin(item_i.first_byte, item_i.message_length,
                           item_i.second_byte, item_i.third_byte);
    p2        = (item_i.message_length > 2'd1) ? item_i.second_byte : 8'h00;
    p3        = (item_i.message_length > 2'd2) ? item_i.third_byte : 8'h00;
    if (item_i.command == CmdDecode) begin
      run_o.kind  = KindStreamByte;
      run_o.port  = dec_cable;
      run_o.count = cable_ok ? decode_count(item_i.header_byte[3:0]) : 2'd0;
      run_o.bytes = {item_i.third_byte, item_i.second_byte, item_i.first_byte};
      run_o.word  = 32'h0;
    end else begin
      run_o.kind  = KindPacket;
      run_o.port  = 4'h0;
      run_o.count = (item_i.message_length == 2'd0) ? 2'd0 : 2'd1;
      run_o.bytes = '0;
      run_o.word  = {p3, p2, item_i.first_byte, item_i.cable_number, cin};
    end
  end

endmodule

// File: rtl/upc_out_stage.sv
module upc_out_stage import upc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  upc_run_t   run_i,
  output logic       load_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_kind_o,
  output logic [3:0] port_index_o,
  output logic [7:0] stream_byte_o,
  output logic [31:0] packet_word_o,
  output logic       last_of_run_o
);

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  upc_run_t   run_q;
  logic       take, last;

  always_comb begin
    last    = (idx_q + 2'd1) == run_q.count;
    take    = valid_q && out_ready_i;
    load_o  = !valid_q || (take && last);
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_o) begin
      valid_d = item_valid_i && (run_i.count != 2'd0);
      idx_d   = 2'd0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o && item_valid_i) begin
      run_q <= run_i;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    stream_byte_o = run_q.bytes[0];
      2'd1:    stream_byte_o = run_q.bytes[1];
      default: stream_byte_o = run_q.bytes[2];
    endcase
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = run_q.kind;
  assign port_index_o  = run_q.port;
  assign packet_word_o = run_q.word;
  assign last_of_run_o = last;

endmodule

// File: rtl/usb_midi_event_packet_codec_unit.sv
// Each item is registered in the input stage and then in the result register, where its
// first result is presented and can transfer once the receiver is ready.
// Throughput: one item per cycle for items that give at most one result, while the
// receiver accepts them; a decoded packet holds the result register until its stream
// bytes, up to three, are transferred. Items with no result are dropped in the result stage.
// Reset clears the valid flags and the byte index; data registers are not reset.
module usb_midi_event_packet_codec_unit import upc_pkg::*; #(
  parameter int unsigned CABLE_COUNT = CableCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  header_byte_i,
  input  logic [3:0]  cable_number_i,
  input  logic [1:0]  message_length_i,
  input  logic [7:0]  first_byte_i,
  input  logic [7:0]  second_byte_i,
  input  logic [7:0]  third_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [3:0]  port_index_o,
  output logic [7:0]  stream_byte_o,
  output logic [31:0] packet_word_o,
  output logic        last_of_run_o
);

  upc_item_t in_item, stage_item;
  upc_run_t  run;
  logic      stage_valid, load;

  assign in_item = '{command:        command_i,
                     header_byte:    header_byte_i,
                     cable_number:   cable_number_i,
                     message_length: message_length_i,
                     first_byte:     first_byte_i,
                     second_byte:    second_byte_i,
                     third_byte:     third_byte_i};

  upc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .load_i       (load),
    .item_valid_o (stage_valid),
    .item_o       (stage_item)
  );

  upc_pack #(
    .CABLE_COUNT (CABLE_COUNT)
  ) u_pack (
    .item_i (stage_item),
    .run_o  (run)
  );

  upc_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (stage_valid),
    .run_i         (run),
    .load_o        (load),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .port_index_o  (port_index_o),
    .stream_byte_o (stream_byte_o),
    .packet_word_o (packet_word_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: bench/tb_top.sv
module tb_top;
  import upc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CableLimit = CableCountDef;
  localparam int unsigned ErrorCap = 100;

  localparam logic [3:0] CinMisc            = 4'h0;
  localparam logic [3:0] CinCableEvent      = 4'h1;
  localparam logic [3:0] CinNoteOff         = 4'h8;
  localparam logic [3:0] CinNoteOn          = 4'h9;
  localparam logic [3:0] CinPolyPressure    = 4'hA;
  localparam logic [3:0] CinControlChange   = 4'hB;
  localparam logic [3:0] CinProgramChange   = 4'hC;
  localparam logic [3:0] CinChannelPressure = 4'hD;
  localparam logic [3:0] CinPitchBend       = 4'hE;
  localparam logic [3:0] CinRawByte         = 4'hF;

  localparam logic [7:0] StatusNoteOff      = 8'h80;
  localparam logic [7:0] StatusNoteOn       = 8'h90;
  localparam logic [7:0] StatusPitchBend    = 8'hE0;
  localparam logic [7:0] StatusUndefinedF4  = 8'hF4;

  typedef struct packed {
    logic        kind;
    logic [3:0]  port;
    logic [7:0]  sbyte;
    logic [31:0] word;
    logic        last;
  } midi_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic        command;
  logic [7:0]  header_byte;
  logic [3:0]  cable_number;
  logic [1:0]  message_length;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic [7:0]  third_byte;
  logic        out_valid_o;
  logic        out_ready;
  logic        result_kind_o;
  logic [3:0]  port_index_o;
  logic [7:0]  stream_byte_o;
  logic [31:0] packet_word_o;
  logic        last_of_run_o;

  midi_result_t results_due[$];
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_request = 0;
  int failures = 0;
  int decodes_sent = 0;
  int encodes_sent = 0;
  int results_seen = 0;

  usb_midi_event_packet_codec_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .command_i        (command),
    .header_byte_i    (header_byte),
    .cable_number_i   (cable_number),
    .message_length_i (message_length),
    .first_byte_i     (first_byte),
    .second_byte_i    (second_byte),
    .third_byte_i     (third_byte),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .result_kind_o    (result_kind_o),
    .port_index_o     (port_index_o),
    .stream_byte_o    (stream_byte_o),
    .packet_word_o    (packet_word_o),
    .last_of_run_o    (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned bytes_for_cin(input logic [3:0] cin);
    int unsigned n;
    case (cin)
      CinMisc, CinCableEvent:                    n = 0;
      CinSingleByte, CinRawByte:                 n = 1;
      CinTwoByteCommon, CinSysexEndTwo,
      CinProgramChange, CinChannelPressure:      n = 2;
      default:                                   n = 3;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] packet_cin(input logic [7:0] status, input logic [1:0] len,
                                            input logic [7:0] d0, input logic [7:0] d1);
    logic [3:0] cin;
    if (status[7] && status < StatusSysexStart) begin
      cin = status[7:4];
    end else begin
      case (status)
        StatusTimeCode, StatusSongSelect: cin = CinTwoByteCommon;
        StatusSongPosition:               cin = CinThreeByteCommon;
        StatusSysexStart:                 cin = CinSysexStart;
        StatusTuneRequest, StatusClock, StatusStart, StatusContinue,
        StatusStop, StatusActiveSense, StatusReset: cin = CinSingleByte;
        default: begin
          case (len)
            2'd2:    cin = (d0 == StatusSysexEnd) ? CinSysexEndTwo : CinTwoByteCommon;
            2'd3:    cin = (d1 == StatusSysexEnd) ? CinSysexEndThree : CinThreeByteCommon;
            default: cin = CinSingleByte;
          endcase
        end
      endcase
    end
    return cin;
  endfunction

  task automatic derive_codec_results(input upc_item_t item);
    midi_result_t r;
    logic [3:0] cable;
    logic [7:0] payload[3];
    logic [7:0] p2;
    logic [7:0] p3;
    int unsigned n;
    if (item.command == CmdDecode) begin
      decodes_sent++;
      cable = item.header_byte[7:4];
      if (cable >= CableLimit) return;
      n = bytes_for_cin(item.header_byte[3:0]);
      payload[0] = item.first_byte;
      payload[1] = item.second_byte;
      payload[2] = item.third_byte;
      for (int k = 0; k < n; k++) begin
        r.kind  = KindStreamByte;
        r.port  = cable;
        r.sbyte = payload[k];
        r.word  = '0;
        r.last  = (k == n - 1);
        results_due.push_back(r);
      end
    end else begin
      encodes_sent++;
      if (item.message_length == 2'd0) return;
      p2 = (item.message_length > 2'd1) ? item.second_byte : 8'h00;
      p3 = (item.message_length > 2'd2) ? item.third_byte : 8'h00;
      r.kind  = KindPacket;
      r.port  = '0;
      r.sbyte = '0;
      r.word  = {p3, p2, item.first_byte, item.cable_number,
                 packet_cin(item.first_byte, item.message_length,
                            item.second_byte, item.third_byte)};
      r.last  = 1'b1;
      results_due.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    midi_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= ErrorCap) $error("Result transfer arrived with nothing expected.");
      end else begin
        exp_r = results_due.pop_front();
        if (result_kind_o !== exp_r.kind) begin
          failures++;
          if (failures <= ErrorCap)
            $error("result_kind: expected %0h, actual %0h", exp_r.kind, result_kind_o);
        end
        if (port_index_o !== exp_r.port) begin
          failures++;
          if (failures <= ErrorCap)
            $error("port_index: expected %0h, actual %0h", exp_r.port, port_index_o);
        end
        if (stream_byte_o !== exp_r.sbyte) begin
          failures++;
          if (failures <= ErrorCap)
            $error("stream_byte: expected %0h, actual %0h", exp_r.sbyte, stream_byte_o);
        end
        if (packet_word_o !== exp_r.word) begin
          failures++;
          if (failures <= ErrorCap)
            $error("packet_word: expected %0h, actual %0h", exp_r.word, packet_word_o);
        end
        if (last_of_run_o !== exp_r.last) begin
          failures++;
          if (failures <= ErrorCap)
            $error("last_of_run: expected %0h, actual %0h", exp_r.last, last_of_run_o);
        end
      end
    end
  end

  // The receiver stalls for a random count after each transfer while idle
  // stalls are on, or for a long stretch when a test asks for one.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (out_valid_o && out_ready) begin
        stall_left = rx_idle ? $urandom_range(0, 7) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  task automatic send_item(input upc_item_t item);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    command        <= item.command;
    header_byte    <= item.header_byte;
    cable_number   <= item.cable_number;
    message_length <= item.message_length;
    first_byte     <= item.first_byte;
    second_byte    <= item.second_byte;
    third_byte     <= item.third_byte;
    do @(posedge clk_i); while (!in_ready_o);
    derive_codec_results(item);
  endtask

  task automatic wait_for_drain();
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic upc_item_t decode_item(input logic [3:0] cable, input logic [3:0] cin,
                                            input logic [7:0] b1, input logic [7:0] b2,
                                            input logic [7:0] b3);
    upc_item_t item;
    item.command        = CmdDecode;
    item.header_byte    = {cable, cin};
    item.cable_number   = 4'($urandom_range(0, 15));
    item.message_length = 2'($urandom_range(0, 3));
    item.first_byte     = b1;
    item.second_byte    = b2;
    item.third_byte     = b3;
    return item;
  endfunction

  function automatic upc_item_t encode_item(input logic [3:0] cable, input logic [1:0] len,
                                            input logic [7:0] status, input logic [7:0] d0,
                                            input logic [7:0] d1);
    upc_item_t item;
    item.command        = CmdEncode;
    item.header_byte    = 8'($urandom_range(0, 255));
    item.cable_number   = cable;
    item.message_length = len;
    item.first_byte     = status;
    item.second_byte    = d0;
    item.third_byte     = d1;
    return item;
  endfunction

  function automatic logic [7:0] random_data_byte();
    return ($urandom_range(0, 5) == 0) ? StatusSysexEnd : 8'($urandom_range(0, 255));
  endfunction

  function automatic upc_item_t random_item();
    logic [3:0] cable;
    logic [7:0] status;
    if ($urandom_range(0, 1) == 0) begin
      cable = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(CableLimit, 15))
                                          : 4'($urandom_range(0, CableLimit - 1));
      return decode_item(cable, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 2))
      0:       status = 8'($urandom_range(StatusNoteOff, StatusSysexStart - 1));
      1:       status = 8'($urandom_range(StatusSysexStart, StatusReset));
      default: status = 8'($urandom_range(0, 127));
    endcase
    return encode_item(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), status,
                       random_data_byte(), random_data_byte());
  endfunction

  task automatic test_directed_decode();
    send_item(decode_item(4'd0, CinMisc, 8'hFF, 8'hFF, 8'hFF));
    send_item(decode_item(4'd1, CinCableEvent, 8'h12, 8'h34, 8'h56));
    send_item(decode_item(4'd0, CinSingleByte, 8'hF8, 8'h00, 8'h00));
    send_item(decode_item(4'(CableLimit - 1), CinTwoByteCommon, 8'hF1, 8'h7F, 8'hAA));
    send_item(decode_item(4'd1, CinThreeByteCommon, 8'hFF, 8'hFF, 8'hFF));
    send_item(decode_item(4'd2, CinRawByte, 8'h00, 8'h00, 8'h00));
    send_item(decode_item(4'd0, CinPitchBend, 8'hE5, 8'h01, 8'h40));
    send_item(decode_item(4'd3, CinProgramChange, 8'hC0, 8'h05, 8'h99));
    send_item(decode_item(4'(CableLimit), CinNoteOn, 8'h90, 8'h3C, 8'h7F));
    send_item(decode_item(4'd15, CinNoteOff, 8'h80, 8'h3C, 8'h00));
  endtask

  task automatic test_directed_encode();
    send_item(encode_item(4'd0, 2'd3, StatusNoteOn, 8'h3C, 8'h7F));
    send_item(encode_item(4'd15, 2'd3, StatusPitchBend, 8'hFF, 8'hFF));
    send_item(encode_item(4'd1, 2'd2, StatusNoteOff, 8'h40, 8'h11));
    send_item(encode_item(4'd2, 2'd3, StatusSysexStart, 8'h7E, 8'h01));
    send_item(encode_item(4'd3, 2'd2, StatusTimeCode, 8'h21, 8'h00));
    send_item(encode_item(4'd4, 2'd3, StatusSongPosition, 8'h10, 8'h20));
    send_item(encode_item(4'd5, 2'd1, StatusClock, 8'h55, 8'h66));
    send_item(encode_item(4'd6, 2'd1, StatusSysexEnd, 8'h00, 8'h00));
    send_item(encode_item(4'd7, 2'd2, 8'h12, StatusSysexEnd, 8'h00));
    send_item(encode_item(4'd8, 2'd3, 8'h00, 8'h34, StatusSysexEnd));
    send_item(encode_item(4'd9, 2'd3, 8'h7F, 8'h34, 8'h56));
    send_item(encode_item(4'd10, 2'd2, StatusUndefinedF4, 8'h01, 8'h02));
    send_item(encode_item(4'd11, 2'd0, StatusNoteOn, 8'h3C, 8'h7F));
    send_item(encode_item(4'd12, 2'd1, StatusReset, 8'hFF, 8'hFF));
  endtask

  task automatic test_random_traffic();
    repeat (90) send_item(random_item());
  endtask

  task automatic test_back_to_back();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (25) send_item(random_item());
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_output_stall();
    tx_idle = 1'b0;
    hold_request = 80;
    repeat (20) send_item(decode_item(4'($urandom_range(0, CableLimit - 1)), CinControlChange,
                                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))));
    tx_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (6) send_item(random_item());
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait_for_drain();
    repeat (6) send_item(random_item());
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid       <= 1'b0;
    command        <= CmdDecode;
    header_byte    <= '0;
    cable_number   <= '0;
    message_length <= '0;
    first_byte     <= '0;
    second_byte    <= '0;
    third_byte     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_decode();
    test_directed_encode();
    test_random_traffic();
    test_back_to_back();
    test_output_stall();
    test_drain_pause();

    in_valid <= 1'b0;
    repeat (4000) begin
      if (results_due.size() == 0) break;
      @(posedge clk_i);
    end
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived.", results_due.size());
      failures += results_due.size();
    end
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d decode and %0d encode items with %0d result transfers,",
             decodes_sent, encodes_sent, results_seen);
    $display("including reserved codes, foreign cables, empty messages and long output stalls.");
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
